>>> hdl/sync_crc8_frame_receiver_macros.svh
// Assertion macros for the sync-byte framed receiver checker.
// Needs no package; expects clock and reset names at the point of use.
`ifndef SYNC_CRC8_FRAME_RECEIVER_MACROS_SVH
`define SYNC_CRC8_FRAME_RECEIVER_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define SCFR_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Short form on the checker's clk_i / rst_ni.
`define SCFR_ASSERT(label, prop, msg) \
  `SCFR_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> hdl/scfr_pkg.sv
// Package for the sync-byte framed receiver: widths, constants, codes, types.
// No dependencies.
`timescale 1ns / 1ps

package scfr_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned NibbleW    = 4;
  localparam int unsigned FrameLen   = 4;
  localparam int unsigned IdxW       = $clog2(FrameLen);

  localparam logic [ByteW-1:0]   SYNC_RESET  = 8'h12;
  localparam logic [ByteW-1:0]   CRC_INIT    = 8'hFF;
  localparam logic [ByteW-1:0]   CRC_POLY    = 8'h31;
  localparam logic [NibbleW-1:0] NIBBLE_MASK = 4'hF;
  localparam logic [IdxW-1:0]    LAST_IDX    = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0]    LAST_CRC_IDX = IdxW'(FrameLen - 2);

  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CRC   = 4'b0010,
    ST_CHECK = 4'b0100,
    ST_SYNC  = 4'b1000
  } scfr_state_e;

  typedef struct packed {
    logic start;
    logic step;
  } scfr_crc_ctrl_t;

endpackage

>>> hdl/scfr_ifs.sv
// Valid/ready channel interfaces: received bytes in, frame results out.
// Depends on scfr_pkg.
`timescale 1ns / 1ps

interface scfr_byte_if
  import scfr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scfr_result_if
  import scfr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               status;
  logic [ByteW-1:0]   payload_first;
  logic [ByteW-1:0]   payload_second;
  logic [NibbleW-1:0] command_nibble;
  logic [ByteW-1:0]   received_check;

  modport source (output valid, output status, output payload_first, output payload_second,
                  output command_nibble, output received_check, input ready);
  modport sink   (input valid, input status, input payload_first, input payload_second,
                  input command_nibble, input received_check, output ready);
endinterface

>>> hdl/sync_crc8_frame_receiver.sv
// Top level of the sync-byte framed receiver with CRC-8 frame check.
// Depends on scfr_pkg, scfr_ifs and scfr_crc_unit.
//
// Usage:
//   rx_byte_if (sink) takes one received byte per transfer. result_if (source)
//   gives one result per completed 4-byte frame: status 0 for a good CRC with
//   the command nibble, status 1 for a mismatch with the nibble at 0.
//   cfg_we_i/cfg_wdata_i write the sync byte; write only while idle.
// Timing:
//   A byte that does not complete a frame is taken in idle; the next byte may
//   follow in the next cycle. A byte that completes a frame passes through
//   3 CRC byte steps on the shared CRC unit and then the check into the
//   result register, and after a mismatch through a resync search, one
//   stored byte compared per cycle. No new byte is taken until the
//   sequencer is back in idle.
// Reset:
//   Clears the fill count, the sequencer and the result valid; the sync
//   byte returns to 0x12.
// Stall:
//   A held result stays in the output register while new bytes are taken;
//   the next result waits in the check step until the register frees.
`timescale 1ns / 1ps

module sync_crc8_frame_receiver
  import scfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ByteW-1:0]  cfg_wdata_i,
  scfr_byte_if.sink         rx_byte_if,
  scfr_result_if.source     result_if
);

  scfr_state_e      state_q, state_d;
  logic [ByteW-1:0] sync_q;
  logic [ByteW-1:0] store_q [FrameLen];
  logic [IdxW-1:0]  fill_q, fill_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [IdxW-1:0]  rem_q, rem_d;
  logic             out_valid_q, out_valid_d;
  logic             out_status_q;
  logic [ByteW-1:0] out_first_q, out_second_q, out_check_q;
  logic [NibbleW-1:0] out_nibble_q;

  logic             rx_xfer, out_xfer, load_out, crc_good, is_sync_in, is_sync_next;
  logic [ByteW-1:0] crc;
  scfr_crc_ctrl_t   crc_ctrl;

  assign rx_byte_if.ready = (state_q == ST_IDLE);
  assign rx_xfer  = rx_byte_if.valid && rx_byte_if.ready;
  assign out_xfer = out_valid_q && result_if.ready;

  assign is_sync_in   = (rx_byte_if.rx_byte == sync_q);
  assign is_sync_next = (store_q[1] == sync_q);
  assign crc_good     = (crc == store_q[LAST_IDX]);
  assign load_out     = (state_q == ST_CHECK) && (!out_valid_q || result_if.ready);

  assign crc_ctrl.start = rx_xfer;
  assign crc_ctrl.step  = (state_q == ST_CRC);

  scfr_crc_unit u_crc (
    .clk_i  (clk_i),
    .ctrl_i (crc_ctrl),
    .data_i (store_q[idx_q]),
    .crc_o  (crc)
  );

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (rx_xfer && (fill_q != '0 || is_sync_in)) begin
          if (fill_q == LAST_IDX) begin
            state_d = ST_CRC;
            idx_d   = '0;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_CRC: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_CRC_IDX) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          if (crc_good) begin
            fill_d  = '0;
            state_d = ST_IDLE;
          end else begin
            rem_d   = LAST_IDX;
            state_d = ST_SYNC;
          end
        end
      end
      ST_SYNC: begin
        if (rem_q == '0) begin
          fill_d  = '0;
          state_d = ST_IDLE;
        end else if (is_sync_next) begin
          fill_d  = rem_q;
          state_d = ST_IDLE;
        end else begin
          rem_d = rem_q - 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      sync_q      <= SYNC_RESET;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
    end
  end

  // Frame store: write at the fill position, shift down during resync.
  always_ff @(posedge clk_i) begin
    if (rx_xfer) begin
      store_q[fill_q] <= rx_byte_if.rx_byte;
    end else if (state_q == ST_SYNC && rem_q != '0) begin
      for (int j = 0; j < FrameLen - 1; j++) begin
        store_q[j] <= store_q[j+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= crc_good ? STATUS_GOOD : STATUS_BAD;
      out_first_q  <= store_q[1];
      out_second_q <= store_q[2];
      out_nibble_q <= crc_good ? (store_q[2][NibbleW-1:0] & NIBBLE_MASK) : '0;
      out_check_q  <= store_q[LAST_IDX];
    end
  end

  assign result_if.valid          = out_valid_q;
  assign result_if.status         = out_status_q;
  assign result_if.payload_first  = out_first_q;
  assign result_if.payload_second = out_second_q;
  assign result_if.command_nibble = out_nibble_q;
  assign result_if.received_check = out_check_q;

endmodule

>>> hdl/scfr_crc_unit.sv
// CRC-8 accumulator (poly 0x31, init 0xFF, MSB first), one byte per step.
// Depends on scfr_pkg.
`timescale 1ns / 1ps

module scfr_crc_unit
  import scfr_pkg::*;
(
  input  logic             clk_i,
  input  scfr_crc_ctrl_t   ctrl_i,
  input  logic [ByteW-1:0] data_i,
  output logic [ByteW-1:0] crc_o
);

  logic [ByteW-1:0] crc_q, crc_d, step_crc;

  always_comb begin
    step_crc = crc_q ^ data_i;
    for (int b = 0; b < ByteW; b++) begin
      if (step_crc[ByteW-1]) begin
        step_crc = {step_crc[ByteW-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        step_crc = {step_crc[ByteW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    crc_d = crc_q;
    if (ctrl_i.start) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.step) begin
      crc_d = step_crc;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

>>> hdl/scfr_checker.sv
// Port-level checker for the sync-byte framed receiver, bound to the top level.
// Depends on scfr_pkg and sync_crc8_frame_receiver_macros.svh.
`timescale 1ns / 1ps
`include "sync_crc8_frame_receiver_macros.svh"

module scfr_checker
  import scfr_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               rx_valid_i,
  input logic               rx_ready_i,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input logic               res_status_i,
  input logic [ByteW-1:0]   res_payload_second_i,
  input logic [NibbleW-1:0] res_command_nibble_i
);

  `SCFR_ASSERT(a_res_valid_hold, res_valid_i && !res_ready_i |=> res_valid_i, "result dropped while stalled")
  `SCFR_ASSERT(a_no_instant_result, rx_valid_i && rx_ready_i && !res_valid_i |=> !res_valid_i, "result too soon after byte transfer")
  `SCFR_ASSERT(a_good_nibble, res_valid_i && res_status_i == STATUS_GOOD |-> res_command_nibble_i == res_payload_second_i[NibbleW-1:0], "command nibble mismatch")
  `SCFR_ASSERT(a_bad_nibble, res_valid_i && res_status_i == STATUS_BAD |-> res_command_nibble_i == '0, "command taken from bad frame")

endmodule

bind sync_crc8_frame_receiver scfr_checker u_scfr_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .rx_valid_i           (rx_byte_if.valid),
  .rx_ready_i           (rx_byte_if.ready),
  .res_valid_i          (result_if.valid),
  .res_ready_i          (result_if.ready),
  .res_status_i         (result_if.status),
  .res_payload_second_i (result_if.payload_second),
  .res_command_nibble_i (result_if.command_nibble)
);

>>> sim/tb_sync_crc8_frame_receiver.sv
// Self-checking testbench for sync_crc8_frame_receiver: random byte stream with
// framed requests, CRC-8 prediction, and sync byte changes between phases.
// Depends on scfr_pkg, scfr_ifs and the receiver RTL.
`timescale 1ns / 1ps

module tb_sync_crc8_frame_receiver;
  import scfr_pkg::*;

  typedef struct {
    logic               status;
    logic [ByteW-1:0]   payload_first;
    logic [ByteW-1:0]   payload_second;
    logic [NibbleW-1:0] command_nibble;
    logic [ByteW-1:0]   received_check;
  } frame_result_t;

  class frame_scoreboard;
    logic [ByteW-1:0] sync_byte;
    logic [ByteW-1:0] held [FrameLen];
    int unsigned      held_cnt;
    frame_result_t    awaited [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      kept;

    function new();
      sync_byte = SYNC_RESET;
      held_cnt  = 0;
      errors    = 0;
      checked   = 0;
      kept      = 0;
    endfunction

    static function logic [ByteW-1:0] crc8_of(input logic [ByteW-1:0] b0,
                                              input logic [ByteW-1:0] b1,
                                              input logic [ByteW-1:0] b2);
      logic [ByteW-1:0] crc;
      logic [ByteW-1:0] msg [3];
      msg[0] = b0;
      msg[1] = b1;
      msg[2] = b2;
      crc = CRC_INIT;
      for (int i = 0; i < 3; i++) begin
        crc = crc ^ msg[i];
        for (int k = 0; k < ByteW; k++) begin
          if (crc[ByteW-1]) begin
            crc = (crc << 1) ^ CRC_POLY;
          end else begin
            crc = crc << 1;
          end
        end
      end
      return crc;
    endfunction

    function void set_sync(input logic [ByteW-1:0] value);
      sync_byte = value;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void note_byte(input logic [ByteW-1:0] rx);
      int unsigned   pos;
      bit            good;
      frame_result_t r;
      pos = held_cnt;
      held[pos] = rx;
      if (pos != 0 || rx == sync_byte) begin
        pos++;
        kept++;
      end
      if (pos < FrameLen) begin
        held_cnt = pos;
        return;
      end
      good = crc8_of(held[0], held[1], held[2]) == held[3];
      r.status         = good ? STATUS_GOOD : STATUS_BAD;
      r.payload_first  = held[1];
      r.payload_second = held[2];
      r.command_nibble = good ? (held[2][NibbleW-1:0] & NIBBLE_MASK) : '0;
      r.received_check = held[3];
      awaited.push_back(r);
      held_cnt = 0;
      // resync on the first later stored sync byte
      if (!good) begin
        for (int unsigned i = 1; i < FrameLen; i++) begin
          if (held[i] == sync_byte) begin
            for (int unsigned j = 0; j < FrameLen - i; j++) begin
              held[j] = held[i + j];
            end
            held_cnt = FrameLen - i;
            break;
          end
        end
      end
    endfunction

    task report(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      errors++;
    endtask

    task check_result(input frame_result_t got);
      frame_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with none pending: status %0b check %02h",
                         got.status, got.received_check));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.status !== want.status) begin
        report($sformatf("status %0b, want %0b", got.status, want.status));
      end
      if (got.payload_first !== want.payload_first) begin
        report($sformatf("payload_first %02h, want %02h",
                         got.payload_first, want.payload_first));
      end
      if (got.payload_second !== want.payload_second) begin
        report($sformatf("payload_second %02h, want %02h",
                         got.payload_second, want.payload_second));
      end
      if (got.command_nibble !== want.command_nibble) begin
        report($sformatf("command_nibble %0h, want %0h",
                         got.command_nibble, want.command_nibble));
      end
      if (got.received_check !== want.received_check) begin
        report($sformatf("received_check %02h, want %02h",
                         got.received_check, want.received_check));
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [ByteW-1:0] cfg_wdata_i;
  bit               calm;
  int unsigned      settings;
  frame_scoreboard  sb;

  scfr_byte_if   rx_if ();
  scfr_result_if res_if ();

  sync_crc8_frame_receiver DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_byte_if  (rx_if),
    .result_if   (res_if)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #8_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] value);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 14);
    @(negedge clk_i);
    if (gap > 0) begin
      rx_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   = 1'b1;
    rx_if.rx_byte = value;
    do @(posedge clk_i); while (!(rx_if.valid && rx_if.ready === 1'b1));
    sb.note_byte(value);
  endtask

  task automatic send_frame(input logic [ByteW-1:0] b0, input logic [ByteW-1:0] b1,
                            input logic [ByteW-1:0] b2, input logic [ByteW-1:0] b3);
    send_byte(b0);
    send_byte(b1);
    send_byte(b2);
    send_byte(b3);
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    rx_if.valid = 1'b0;
  endtask

  task automatic write_sync(input logic [ByteW-1:0] value);
    hold_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (12) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(posedge clk_i);
    sb.set_sync(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    settings++;
  endtask

  function automatic logic [ByteW-1:0] pick_payload();
    if ($urandom_range(0, 4) == 0) begin
      return sb.sync_byte;
    end
    return ByteW'($urandom_range(0, 255));
  endfunction

  task automatic send_random_unit();
    logic [ByteW-1:0] s;
    logic [ByteW-1:0] p1;
    logic [ByteW-1:0] p2;
    logic [ByteW-1:0] chk;
    int unsigned      kind;
    s    = sb.sync_byte;
    p1   = pick_payload();
    p2   = pick_payload();
    chk  = frame_scoreboard::crc8_of(s, p1, p2);
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      send_frame(s, p1, p2, chk);
    end else if (kind < 65) begin
      send_frame(s, p1, p2, chk ^ (ByteW'(1) << $urandom_range(0, ByteW - 1)));
    end else if (kind < 75) begin
      send_frame(s, s, pick_payload(), $urandom_range(0, 1) ? s : pick_payload());
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 3)) send_byte(ByteW'($urandom_range(0, 255)));
    end else begin
      send_byte(s);
      repeat ($urandom_range(1, 2)) send_byte(pick_payload());
    end
  endtask

  task automatic run_directed();
    logic [ByteW-1:0] s;
    logic [ByteW-1:0] chk;
    s = sb.sync_byte;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(s, 8'h00, 8'hFF, frame_scoreboard::crc8_of(s, 8'h00, 8'hFF));
    chk = frame_scoreboard::crc8_of(s, 8'hA5, 8'h5A) ^ 8'h80;
    send_frame(s, 8'hA5, 8'h5A, chk);
    chk = frame_scoreboard::crc8_of(s, s, 8'hF0) ^ 8'h01;
    send_frame(s, s, 8'hF0, chk);
    send_byte(frame_scoreboard::crc8_of(s, 8'hF0, chk));
    chk = frame_scoreboard::crc8_of(s, 8'h3C, s) ^ 8'hFF;
    send_frame(s, 8'h3C, s, chk);
    send_byte(8'h0F);
    send_byte(frame_scoreboard::crc8_of(s, chk, 8'h0F));
    send_frame(s, 8'hC3, 8'h7E, s);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(frame_scoreboard::crc8_of(s, 8'h01, 8'h80));
  endtask

  task automatic run_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = sb.kept + count;
    while (sb.kept < stop_at) begin
      if ($urandom_range(0, 39) == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      send_random_unit();
    end
  endtask

  initial begin : sink
    int unsigned   stall;
    frame_result_t got;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 14);
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!(res_if.valid === 1'b1 && res_if.ready));
      got.status         = res_if.status;
      got.payload_first  = res_if.payload_first;
      got.payload_second = res_if.payload_second;
      got.command_nibble = res_if.command_nibble;
      got.received_check = res_if.received_check;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [ByteW-1:0] sync_list [5];
    sb            = new();
    settings      = 1;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    sync_list[0]  = 8'h00;
    sync_list[1]  = 8'hFF;
    sync_list[2]  = ByteW'($urandom_range(0, 255));
    sync_list[3]  = 8'hA5;
    sync_list[4]  = SYNC_RESET;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_phase(120);
    for (int i = 0; i < 5; i++) begin
      write_sync(sync_list[i]);
      run_phase(140);
    end

    hold_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d frame bytes under %0d sync settings, checked %0d frame results",
             sb.kept, settings, sb.checked);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/scfr_pkg.sv
hdl/scfr_ifs.sv
hdl/scfr_crc_unit.sv
hdl/sync_crc8_frame_receiver.sv
hdl/scfr_checker.sv
sim/tb_sync_crc8_frame_receiver.sv
